FILE: hw/rtl/sha256_digest_engine_assert.svh
// assertion macros for the sha256 digest engine
`ifndef SHA256_DIGEST_ENGINE_ASSERT_SVH
`define SHA256_DIGEST_ENGINE_ASSERT_SVH

// a request held by valid and not taken keeps its payload
`define SDE_HOLD(lbl, vld, rdy, pay) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(pay)) else $error("payload changed while stalled");

// a condition that must hold in every cycle out of reset
`define SDE_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant broken");

// an event implies a condition in the next cycle
`define SDE_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence broken");

`endif

FILE: hw/rtl/sha_pkg.sv
package sha_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       final_item;
    } req_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: hw/rtl/sha_front.sv
// request queue: drops empty non-final requests, buffers the rest
module sha_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  sha_pkg::req_t     req,
    output logic              q_valid,
    input  logic              q_ready,
    output sha_pkg::req_t     q_req
);
    sha_pkg::req_t                 mem_reg [sha_pkg::QUEUE_DEPTH];
    logic [sha_pkg::QUEUE_AW-1:0]  wr_reg, rd_reg;
    logic [sha_pkg::QUEUE_AW:0]    cnt_reg;
    logic                          push, pop, keep;

    assign ready   = (cnt_reg != (sha_pkg::QUEUE_AW+1)'(sha_pkg::QUEUE_DEPTH));
    assign keep    = req.byte_present | req.final_item;
    assign push    = valid & ready & keep;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid & q_ready;
    assign q_req   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (sha_pkg::QUEUE_AW+1)'(push) - (sha_pkg::QUEUE_AW+1)'(pop);
        end
    end
endmodule

FILE: hw/rtl/sha_back.sv
// byte packing, padding, 64-round compression and digest output
module sha_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  sha_pkg::req_t     q_req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_word,
    output logic              out_last
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_ZLEN = 3'd5;

    logic [2:0]  state_reg;
    logic [31:0] blk_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic        fin_reg;    // padding pending after this block
    logic        pad_reg;    // current block already holds the pad byte
    logic        lenblk_reg; // current pad block carries the length
    logic [2:0]  oidx_reg;

    logic [31:0] w_cur, w2, w15, s0, s1, t1, t2, ee, aa, ch, mj;
    logic [3:0]  wi;
    logic [1:0]  bi;
    logic        blk_go, len_fits;

    assign q_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_word = h_reg[oidx_reg];
    assign out_last = (oidx_reg == 3'd7);
    assign blk_go   = (state_reg == S_IDLE) && q_valid && q_req.byte_present
                      && (fill_reg == 6'd63);
    assign len_fits = (fill_reg < 6'd56);

    always_comb
    begin
        w2  = w_reg[4'(rnd_reg - 6'd2)];
        w15 = w_reg[4'(rnd_reg - 6'd15)];
        s0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
        s1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
        if (rnd_reg < 6'd16)
            w_cur = blk_reg[rnd_reg[3:0]];
        else
            w_cur = s1 + w_reg[4'(rnd_reg - 6'd7)] + s0 + w_reg[rnd_reg[3:0]];
        aa = v_reg[0];
        ee = v_reg[4];
        ch = (ee & v_reg[5]) ^ (~ee & v_reg[6]);
        mj = (aa & v_reg[1]) ^ (aa & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + (sha_pkg::rotr(ee, 6) ^ sha_pkg::rotr(ee, 11) ^ sha_pkg::rotr(ee, 25))
             + ch + sha_pkg::ROUND_K[rnd_reg] + w_cur;
        t2 = (sha_pkg::rotr(aa, 2) ^ sha_pkg::rotr(aa, 13) ^ sha_pkg::rotr(aa, 22)) + mj;
        wi = fill_reg[5:2];
        bi = fill_reg[1:0];
    end

    // block words: byte lane write, padding fill, length block
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid && q_req.byte_present)
        begin
            blk_reg[wi][8*(3-bi) +: 8] <= q_req.msg_byte;
        end
        else if (state_reg == S_PAD)
        begin
            // pad byte at the fill point, zeros after it, length when it fits
            for (int i = 0; i < 16; i++)
            begin
                if (len_fits && i == 14)
                    blk_reg[i] <= len_reg[63:32];
                else if (len_fits && i == 15)
                    blk_reg[i] <= len_reg[31:0];
                else
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        if (4 * i + k == int'(fill_reg))
                            blk_reg[i][8*(3-k) +: 8] <= sha_pkg::PAD_BYTE;
                        else if (4 * i + k > int'(fill_reg))
                            blk_reg[i][8*(3-k) +: 8] <= 8'd0;
                    end
                end
            end
        end
        else if (state_reg == S_ZLEN)
        begin
            // zeros and the length, after a pad block with no room left
            for (int i = 0; i < 14; i++)
                blk_reg[i] <= 32'd0;
            blk_reg[14] <= len_reg[63:32];
            blk_reg[15] <= len_reg[31:0];
        end
    end

    // round registers and message schedule
    always_ff @(posedge clk)
    begin
        if (blk_go || state_reg == S_PAD || state_reg == S_ZLEN)
        begin
            v_reg <= h_reg;
        end
        else if (state_reg == S_RND)
        begin
            w_reg[rnd_reg[3:0]] <= w_cur;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= ee;
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= aa;
            v_reg[0] <= t1 + t2;
        end
    end

    // control and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            h_reg      <= sha_pkg::INIT_H;
            rnd_reg    <= '0;
            fin_reg    <= 1'b0;
            pad_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            oidx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_req.byte_present)
                        begin
                            fill_reg <= fill_reg + 6'd1;
                            len_reg  <= len_reg + 64'd8;
                        end
                        fin_reg <= q_req.final_item;
                        if (blk_go)
                        begin
                            // block full of data, compress it first
                            state_reg  <= S_RND;
                            rnd_reg    <= '0;
                            pad_reg    <= 1'b0;
                            lenblk_reg <= 1'b0;
                        end
                        else if (q_req.final_item)
                            state_reg <= S_PAD;
                    end
                end
                S_PAD:
                begin
                    state_reg  <= S_RND;
                    rnd_reg    <= '0;
                    pad_reg    <= 1'b1;
                    lenblk_reg <= len_fits;
                end
                S_ZLEN:
                begin
                    state_reg  <= S_RND;
                    rnd_reg    <= '0;
                    pad_reg    <= 1'b1;
                    lenblk_reg <= 1'b1;
                end
                S_RND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                        state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    if (lenblk_reg)
                    begin
                        state_reg <= S_OUT;
                        oidx_reg  <= '0;
                    end
                    else if (pad_reg)
                        state_reg <= S_ZLEN;
                    else if (fin_reg)
                        state_reg <= S_PAD;
                    else
                        state_reg <= S_IDLE;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            h_reg      <= sha_pkg::INIT_H;
                            fill_reg   <= '0;
                            len_reg    <= '0;
                            fin_reg    <= 1'b0;
                            pad_reg    <= 1'b0;
                            lenblk_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hw/rtl/sha256_digest_engine.sv
// sha256 digest engine
// input channel: valid/ready carrying msg_byte, byte_present, final_item.
// one request per message byte; the request marked final_item ends the
// message (byte_present low on it gives an empty trailing item).
// output channel: valid/ready carrying digest_word and digest_last;
// eight words H0..H7 leave per message, digest_last on H7.
// a four-entry request queue decouples the input from the hash core; the
// core takes one byte request per cycle, so bytes flow at one per cycle
// until a block fills; a full 64-byte block then goes through the 64
// rounds and the add, and no request is taken meanwhile.
// the final request leads through a padding setup state, the 64 rounds
// and the add, twice over when the length no longer fits the last block;
// the digest then leaves as eight beats.
// requests with neither a byte nor the final mark are dropped at entry.
// reset clears the queue, the length count and the fill count and loads
// the initial chaining values; the block store needs no clearing.
// a stalled receiver holds the current digest word; the queue keeps
// taking requests until its four entries are full, then ready drops.
module sha256_digest_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [7:0]  msg_byte,
    input  logic        byte_present,
    input  logic        final_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic        digest_last
);
`include "sha256_digest_engine_assert.svh"

    sha_pkg::req_t req, q_req;
    logic          q_valid, q_ready;

    assign req.msg_byte     = msg_byte;
    assign req.byte_present = byte_present;
    assign req.final_item   = final_item;

    sha_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (valid),
        .ready   (ready),
        .req     (req),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_req   (q_req)
    );

    sha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (digest_word),
        .out_last  (digest_last)
    );

    // core never pulls from the queue while a digest is leaving
    `SDE_ALWAYS(a_no_pull_during_out, !(out_valid && q_ready))
    // after the last digest word the core is idle again
    `SDE_NEXT(a_idle_after_last, out_valid && out_ready && digest_last, !out_valid)
    // stalled digest word holds
    `SDE_HOLD(a_out_hold, out_valid, out_ready, digest_word)

endmodule

FILE: bench/tb_sha256_digest_engine.sv
module tb_sha256_digest_engine;
    timeunit 1ns;
    timeprecision 1ps;

    // digest tracker: keeps its own copy of the hash state and the queue of
    // digest words the block still owes us
    class digest_board;
        logic [31:0] chain_h [8];
        logic [7:0]  blk [64];
        int unsigned fill;
        logic [63:0] bit_len;
        logic [31:0] pending_word [$];
        logic        pending_last [$];
        int          mismatches;
        int          stray;

        function new();
            restart();
            mismatches = 0;
            stray = 0;
        endfunction

        function void restart();
            chain_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
            fill = 0;
            bit_len = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] kc [64];
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2;
            kc = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            for (int t = 0; t < 64; t++) begin
                if (t < 16)
                    w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
                else
                    w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10))
                         + w[t-7]
                         + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                         + w[t-16];
            end
            v = chain_h;
            for (int t = 0; t < 64; t++) begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[t] + w[t];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain_h[i] = chain_h[i] + v[i];
        endfunction

        // note one accepted request
        function void note_request(logic [7:0] b, logic present, logic fin);
            if (present) begin
                blk[fill] = b;
                fill++;
                bit_len = bit_len + 64'd8;
                if (fill == 64) begin
                    compress();
                    fill = 0;
                end
            end
            if (!fin)
                return;
            blk[fill] = sha_pkg::PAD_BYTE;
            fill++;
            if (fill > 56) begin
                while (fill < 64) begin
                    blk[fill] = 8'h00;
                    fill++;
                end
                compress();
                fill = 0;
            end
            while (fill < 56) begin
                blk[fill] = 8'h00;
                fill++;
            end
            for (int i = 0; i < 8; i++)
                blk[56+i] = bit_len[63-8*i -: 8];
            compress();
            for (int k = 0; k < 8; k++) begin
                pending_word.push_back(chain_h[k]);
                pending_last.push_back(k == 7);
            end
            restart();
        endfunction

        // compare one digest word with the oldest expectation
        function void check_word(logic [31:0] word, logic last);
            logic [31:0] ew;
            logic        el;
            if (pending_word.size() == 0) begin
                stray++;
                if (mismatches < 10)
                    $display("unexpected digest word %h last %b", word, last);
                mismatches++;
                return;
            end
            ew = pending_word.pop_front();
            el = pending_last.pop_front();
            if (word !== ew || last !== el) begin
                if (mismatches < 10)
                    $display("digest mismatch: expected %h/%b got %h/%b",
                             ew, el, word, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        ready;
    logic [7:0]  msg_byte;
    logic        byte_present;
    logic        final_item;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic        digest_last;

    digest_board board;
    bit          long_hold;
    int          idle_cycles;

    localparam int IDLE_LIMIT = 20000;

    sha256_digest_engine u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (valid),
        .ready        (ready),
        .msg_byte     (msg_byte),
        .byte_present (byte_present),
        .final_item   (final_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digest_word  (digest_word),
        .digest_last  (digest_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // offer one request after a random gap, hold until it is taken
    task automatic send_request(logic [7:0] b, logic present, logic fin);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid        <= 1'b1;
        msg_byte     <= b;
        byte_present <= present;
        final_item   <= fin;
        do
            @(posedge clk);
        while (!ready);
        board.note_request(b, present, fin);
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len - 1; i++) begin
            // an occasional dropped request inside the message
            if ($urandom_range(0, 15) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, 1'b0);
        end
        if (len == 0)
            send_request(8'($urandom), 1'b0, 1'b1);
        else
            send_request(8'($urandom), 1'b1, 1'b1);
    endtask

    // receiver: random stalls, one long hold to back the queue up
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (long_hold) begin
                wait_n = 400;
                long_hold = 1'b0;
            end
            if (wait_n > 0) begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            board.check_word(digest_word, digest_last);
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((valid && ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int sent;
        int len;
        bit hold_done;
        board        = new();
        long_hold    = 1'b0;
        hold_done    = 1'b0;
        rst_n        = 1'b0;
        valid        = 1'b0;
        msg_byte     = 8'h00;
        byte_present = 1'b0;
        final_item   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, byte extremes, dropped request, short messages
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'h5a, 1'b1, 1'b0);
        send_request(8'ha5, 1'b0, 1'b1);

        // random messages; lengths around block and padding boundaries
        sent = 0;
        while (sent < 450) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(54, 65);
                1: len = $urandom_range(118, 129);
                2: len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            if (len > 450 - sent)
                len = 450 - sent;
            // hold the receiver off once while messages keep coming
            if (sent > 100 && !hold_done) begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            send_message(len);
            sent += (len == 0) ? 1 : len;
        end
        valid <= 1'b0;

        while (board.pending_word.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.mismatches == 0 && board.pending_word.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
